// File: rtl/core/lpht_pkg.sv
// ----------------------------------------------------------------------------
// lpht_pkg
// Shared types and codes of the linear-probe hash table.
// ----------------------------------------------------------------------------
package lpht_pkg;

	// Field widths of the input and result words.
	localparam int unsigned VAL_W = 31;
	localparam int unsigned REQ_W = 2;
	localparam int unsigned STS_W = 2;
	localparam int unsigned POS_W = 5;

	typedef logic [VAL_W-1:0] value_t;
	typedef logic [POS_W-1:0] pos_t;

	// Request codes. The fourth code is unused and yields not found.
	localparam logic [REQ_W-1:0] REQ_INSERT = 2'd0;
	localparam logic [REQ_W-1:0] REQ_SEARCH = 2'd1;
	localparam logic [REQ_W-1:0] REQ_DELETE = 2'd2;

	// Result status codes.
	localparam logic [STS_W-1:0] STS_OK        = 2'd0;
	localparam logic [STS_W-1:0] STS_NOT_FOUND = 2'd1;
	localparam logic [STS_W-1:0] STS_FULL      = 2'd2;

	// Control states of the top level.
	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_HASH,
		ST_PROBE,
		ST_EMIT
	} state_t;

endpackage

// File: rtl/core/lpht_home.sv
// ----------------------------------------------------------------------------
// lpht_home
// Remainder unit: value mod SLOTS by a scaled reciprocal, product and remainder registered in turn.
// ----------------------------------------------------------------------------
module lpht_home #(
	parameter int unsigned SLOTS = 16
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  lpht_pkg::value_t         value,
	output logic                     done,
	output logic [$clog2(SLOTS)-1:0] rem
);

	// The reciprocal is ceil(2^(VAL_W + IW) / SLOTS). With IW = clog2(SLOTS)
	// the product shifted down by VAL_W + IW is the exact quotient for every
	// VAL_W-bit value, and the reciprocal fits in VAL_W + 1 bits.
	localparam int unsigned IW = $clog2(SLOTS);
	localparam int unsigned KW = lpht_pkg::VAL_W + 1;
	localparam int unsigned PW = lpht_pkg::VAL_W + KW;
	localparam int unsigned SH = lpht_pkg::VAL_W + IW;
	localparam logic [63:0] SCALE   = 64'd1 << SH;
	localparam logic [63:0] RECIP_W = (SCALE + 64'(SLOTS) - 64'd1) / 64'(SLOTS);
	localparam logic [KW-1:0] RECIP = RECIP_W[KW-1:0];
	localparam logic [IW-1:0] S_LO  = IW'(SLOTS);

	logic             busy_q;
	logic             done_q;
	lpht_pkg::value_t v_q;
	logic [PW-1:0]    prod_q;
	logic [IW-1:0]    q_lo;
	logic [IW-1:0]    qs_lo;
	logic [IW-1:0]    rem_q;

	// The remainder is below 2^IW, so the low IW bits of value - q * SLOTS
	// give it exactly.
	always_comb begin
		q_lo  = prod_q[SH +: IW];
		qs_lo = q_lo * S_LO;
	end

	// Step control: the product is taken at start, the remainder in the cycle after.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			busy_q <= start;
			done_q <= busy_q;
		end
	end

	// Datapath registers need no reset.
	always_ff @(posedge clk) begin
		if (start) begin
			v_q    <= value;
			prod_q <= PW'(value) * PW'(RECIP);
		end
		if (busy_q) begin
			rem_q <= v_q[IW-1:0] - qs_lo;
		end
	end

	assign done = done_q;
	assign rem  = rem_q;

endmodule

// File: rtl/core/linear_probe_hash_table.sv
// ----------------------------------------------------------------------------
// linear_probe_hash_table
// Open-addressing hash table with linear probing, stored in one memory.
//
//   Channel | Direction | Handshake          | Word
//   --------+-----------+--------------------+-------------------------------
//   in      | input     | in_valid/in_stall  | req_type, value
//   out     | output    | out_valid/out_stall| status, position
//
// After reset a clearing pass empties every slot in turn; in_stall is
// high meanwhile. One request is in work at a time. The home slot comes
// from a reciprocal multiply, then a remainder; the probed slots are read
// through the registered memory read, the last read is judged and the
// output is loaded. The result sits in an output register, so the next
// word is taken while the previous result waits on out_stall; a new
// result then waits until the held one is taken.
// ----------------------------------------------------------------------------
module linear_probe_hash_table #(
	parameter int unsigned SLOTS = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [lpht_pkg::REQ_W-1:0]          req_type,
	input  lpht_pkg::value_t                    value,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [lpht_pkg::STS_W-1:0]          status,
	output lpht_pkg::pos_t                      position
);

	localparam int unsigned IW = $clog2(SLOTS);
	localparam int unsigned MW = lpht_pkg::VAL_W + 1;
	localparam logic [IW-1:0] LAST_IDX  = IW'(SLOTS - 1);
	localparam logic [IW:0]   SLOTS_CNT = (IW + 1)'(SLOTS);

	lpht_pkg::state_t state_q, state_d;

	// Request registers.
	logic [lpht_pkg::REQ_W-1:0] req_q;
	lpht_pkg::value_t           value_q;

	// Remainder unit.
	logic          hash_start;
	logic          hash_done;
	logic [IW-1:0] hash_rem;
	logic [IW-1:0] home_idx;

	// Memory: each word holds {used, value}.
	logic [MW-1:0] mem [SLOTS];
	logic          mem_we;
	logic [IW-1:0] mem_waddr;
	logic [MW-1:0] mem_wdata;
	logic          mem_re;
	logic [MW-1:0] rdata_s1;

	// Probe control.
	logic [IW-1:0] clr_cnt_q;
	logic [IW-1:0] probe_idx_q;
	logic [IW:0]   issue_cnt_q;
	logic          rd_vld_s1;
	logic [IW-1:0] idx_s1;
	logic          last_s1;
	logic          slot_used;
	logic          hit;
	logic          probe_end;
	logic          req_ok;
	logic          take_in;
	logic          load_out;
	logic [IW:0]   pos_full;

	// Result registers.
	logic [lpht_pkg::STS_W-1:0] res_status_q;
	lpht_pkg::pos_t             res_pos_q;
	logic                       out_valid_q;
	logic [lpht_pkg::STS_W-1:0] status_q;
	lpht_pkg::pos_t             position_q;

	lpht_home #(.SLOTS(SLOTS)) u_home (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (hash_start),
		.value  (value),
		.done   (hash_done),
		.rem    (hash_rem)
	);

	// Home slot is remainder minus one, wrapped to the last slot.
	assign home_idx = (hash_rem == '0) ? LAST_IDX : hash_rem - 1'b1;

	assign req_ok = (req_q == lpht_pkg::REQ_INSERT) || (req_q == lpht_pkg::REQ_SEARCH) ||
		(req_q == lpht_pkg::REQ_DELETE);

	// Evaluate the slot whose word came back from memory.
	assign slot_used = rdata_s1[MW-1];
	always_comb begin
		if (req_q == lpht_pkg::REQ_INSERT) begin
			hit = rd_vld_s1 && !slot_used;
		end else begin
			hit = rd_vld_s1 && slot_used && (rdata_s1[MW-2:0] == value_q);
		end
	end
	assign probe_end = rd_vld_s1 && (hit || last_s1);
	assign pos_full  = {1'b0, idx_s1} + 1'b1;

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			lpht_pkg::ST_CLEAR: begin
				if (clr_cnt_q == LAST_IDX) state_d = lpht_pkg::ST_IDLE;
			end
			lpht_pkg::ST_IDLE: begin
				if (in_valid) state_d = lpht_pkg::ST_HASH;
			end
			lpht_pkg::ST_HASH: begin
				if (hash_done) state_d = req_ok ? lpht_pkg::ST_PROBE : lpht_pkg::ST_EMIT;
			end
			lpht_pkg::ST_PROBE: begin
				if (probe_end) state_d = lpht_pkg::ST_EMIT;
			end
			lpht_pkg::ST_EMIT: begin
				if (!out_valid_q || !out_stall) state_d = lpht_pkg::ST_IDLE;
			end
			default: state_d = lpht_pkg::ST_IDLE;
		endcase
	end

	// Outputs of the state machine.
	always_comb begin
		in_stall   = 1'b1;
		hash_start = 1'b0;
		mem_we     = 1'b0;
		mem_waddr  = idx_s1;
		mem_wdata  = {1'b0, rdata_s1[MW-2:0]};
		mem_re     = 1'b0;
		load_out   = 1'b0;
		unique case (state_q)
			lpht_pkg::ST_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = clr_cnt_q;
				mem_wdata = '0;
			end
			lpht_pkg::ST_IDLE: begin
				in_stall = 1'b0;
			end
			lpht_pkg::ST_HASH: begin
				hash_start = 1'b0;
			end
			lpht_pkg::ST_PROBE: begin
				mem_re = (issue_cnt_q != SLOTS_CNT) && !probe_end;
				if (hit) begin
					mem_we = 1'b1;
					if (req_q == lpht_pkg::REQ_INSERT) begin
						mem_wdata = {1'b1, value_q};
					end else if (req_q == lpht_pkg::REQ_DELETE) begin
						mem_wdata = {1'b0, rdata_s1[MW-2:0]};
					end else begin
						mem_we = 1'b0;
					end
				end
			end
			lpht_pkg::ST_EMIT: begin
				load_out = !out_valid_q || !out_stall;
			end
			default: in_stall = 1'b1;
		endcase
		take_in = !in_stall && in_valid;
		if (take_in) hash_start = 1'b1;
	end

	// Memory with registered read data.
	always_ff @(posedge clk) begin
		if (mem_we) mem[mem_waddr] <= mem_wdata;
		if (mem_re) rdata_s1 <= mem[probe_idx_q];
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= lpht_pkg::ST_CLEAR;
			clr_cnt_q   <= '0;
			issue_cnt_q <= '0;
			rd_vld_s1   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == lpht_pkg::ST_CLEAR) clr_cnt_q <= clr_cnt_q + 1'b1;
			if (state_q == lpht_pkg::ST_HASH) begin
				issue_cnt_q <= '0;
			end else if (mem_re) begin
				issue_cnt_q <= issue_cnt_q + 1'b1;
			end
			rd_vld_s1 <= mem_re;
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Request, probe and result payload registers.
	always_ff @(posedge clk) begin
		if (take_in) begin
			req_q   <= req_type;
			value_q <= value;
		end
		if (state_q == lpht_pkg::ST_HASH) begin
			probe_idx_q <= home_idx;
		end else if (mem_re) begin
			probe_idx_q <= (probe_idx_q == LAST_IDX) ? '0 : probe_idx_q + 1'b1;
		end
		if (mem_re) begin
			idx_s1  <= probe_idx_q;
			last_s1 <= (issue_cnt_q == SLOTS_CNT - 1'b1);
		end
		if (state_q == lpht_pkg::ST_HASH) begin
			res_status_q <= lpht_pkg::STS_NOT_FOUND;
			res_pos_q    <= '0;
		end else if (state_q == lpht_pkg::ST_PROBE && probe_end) begin
			if (hit) begin
				res_status_q <= lpht_pkg::STS_OK;
				res_pos_q    <= lpht_pkg::pos_t'(pos_full);
			end else if (req_q == lpht_pkg::REQ_INSERT) begin
				res_status_q <= lpht_pkg::STS_FULL;
				res_pos_q    <= '0;
			end else begin
				res_status_q <= lpht_pkg::STS_NOT_FOUND;
				res_pos_q    <= '0;
			end
		end
		if (load_out) begin
			status_q   <= res_status_q;
			position_q <= res_pos_q;
		end
	end

	assign out_valid = out_valid_q;
	assign status    = status_q;
	assign position  = position_q;

endmodule

// File: rtl/core/lpht_checker.sv
// ----------------------------------------------------------------------------
// lpht_checker
// Port-level checks of the linear-probe hash table, bound to the top level.
// ----------------------------------------------------------------------------
module lpht_checker #(
	parameter int unsigned SLOTS = 16
) (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       in_valid,
	input logic                       in_stall,
	input logic [lpht_pkg::REQ_W-1:0] req_type,
	input lpht_pkg::value_t           value,
	input logic                       out_valid,
	input logic                       out_stall,
	input logic [lpht_pkg::STS_W-1:0] status,
	input lpht_pkg::pos_t             position
);

	// A stalled result word stays offered.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result word dropped while stalled");

	// One request at a time: after a word is taken the input stalls.
	a_one_in_work: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("second word taken while a request is in work");

	// A miss or a full table carries no position.
	a_miss_pos: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status != lpht_pkg::STS_OK) |-> position == '0)
		else $error("position set on a failed request");

	// A success names a real slot when the position cannot wrap.
	a_hit_pos: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == lpht_pkg::STS_OK) |-> (SLOTS > 31) || (position != '0))
		else $error("successful request without a position");

endmodule

bind linear_probe_hash_table lpht_checker #(.SLOTS(SLOTS)) u_lpht_checker (.*);

// File: tb/sv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the linear-probe hash table. A short table of
// directed request words runs first (empty table, wrap of the home slot,
// duplicates, the unused code, a full table), then random words built around
// colliding values. Every result word is compared with a local model of the
// table; both sides idle at random, the receiver holds off once for a long
// stretch, and the sender pauses until the table has answered everything.
// ----------------------------------------------------------------------------
module testbench;

	localparam int unsigned SLOTS       = 16;
	localparam int unsigned DIR_N       = 25;
	localparam int unsigned POOL_N      = 20;
	localparam int unsigned HOLD_CYCLES = 300;
	localparam int unsigned TAIL_CYCLES = 64;
	localparam int unsigned MAX_REPORTS = 50;

	// The fourth request code is unused and must answer not found.
	localparam logic [lpht_pkg::REQ_W-1:0] REQ_UNUSED = 2'd3;
	localparam lpht_pkg::value_t VALUE_MAX = {lpht_pkg::VAL_W{1'b1}};

	typedef struct packed {
		logic [lpht_pkg::STS_W-1:0] sts;
		lpht_pkg::pos_t             pos;
	} lookup_t;

	typedef struct packed {
		logic [lpht_pkg::REQ_W-1:0] req;
		lpht_pkg::value_t           val;
		bit                         pinned;
		lookup_t                    res;
	} row_t;

	logic                       clk;
	logic                       arst_n;
	logic                       in_valid;
	logic                       in_stall;
	logic [lpht_pkg::REQ_W-1:0] req_type;
	lpht_pkg::value_t           value;
	logic                       out_valid;
	logic                       out_stall;
	logic [lpht_pkg::STS_W-1:0] status;
	lpht_pkg::pos_t             position;

	// Local copy of the table contents.
	lpht_pkg::value_t tbl_val  [SLOTS];
	bit               tbl_used [SLOTS];
	lpht_pkg::value_t pool     [POOL_N];
	lookup_t          pending_results [$];
	row_t             dir_rows [DIR_N];

	int unsigned fail_count;
	int unsigned words_in;
	int unsigned words_out;
	int unsigned full_inserts;
	int unsigned misses;
	bit          quiet;
	bit          hold_request;

	linear_probe_hash_table #(
		.SLOTS(SLOTS)
	) i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.req_type (req_type),
		.value    (value),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.status   (status),
		.position (position)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Hard limit on the run time.
	initial begin
		#5_000_000;
		$display("Timeout waiting for result words.");
		$display("RESULT: ERROR");
		$finish;
	end

	task automatic report_mismatch(input string msg);
		if (fail_count < MAX_REPORTS)
			$display("MISMATCH at %0t: %s", $realtime, msg);
		fail_count++;
	endtask

	// Apply one request to the local table and return the result it gives.
	function automatic lookup_t probe_table(input logic [lpht_pkg::REQ_W-1:0] req,
			input lpht_pkg::value_t val);
		lookup_t     res;
		int unsigned home;
		int unsigned slot;
		res.sts = lpht_pkg::STS_NOT_FOUND;
		res.pos = '0;
		home = (val % SLOTS == 0) ? SLOTS - 1 : val % SLOTS - 1;
		if (req == lpht_pkg::REQ_INSERT) begin
			res.sts = lpht_pkg::STS_FULL;
			for (int n = 0; n < SLOTS; n++) begin
				slot = (home + n) % SLOTS;
				if (!tbl_used[slot]) begin
					tbl_used[slot] = 1'b1;
					tbl_val[slot]  = val;
					res.sts        = lpht_pkg::STS_OK;
					res.pos        = lpht_pkg::pos_t'(slot + 1);
					break;
				end
			end
		end else if (req == lpht_pkg::REQ_SEARCH || req == lpht_pkg::REQ_DELETE) begin
			for (int n = 0; n < SLOTS; n++) begin
				slot = (home + n) % SLOTS;
				if (tbl_used[slot] && tbl_val[slot] == val) begin
					res.sts = lpht_pkg::STS_OK;
					res.pos = lpht_pkg::pos_t'(slot + 1);
					if (req == lpht_pkg::REQ_DELETE)
						tbl_used[slot] = 1'b0;
					break;
				end
			end
		end
		return res;
	endfunction

	function automatic row_t fixed_row(input logic [lpht_pkg::REQ_W-1:0] req,
			input lpht_pkg::value_t val, input logic [lpht_pkg::STS_W-1:0] sts,
			input lpht_pkg::pos_t pos);
		row_t r;
		r.req     = req;
		r.val     = val;
		r.pinned  = 1'b1;
		r.res.sts = sts;
		r.res.pos = pos;
		return r;
	endfunction

	function automatic row_t open_row(input logic [lpht_pkg::REQ_W-1:0] req,
			input lpht_pkg::value_t val);
		row_t r;
		r.req    = req;
		r.val    = val;
		r.pinned = 1'b0;
		r.res    = '0;
		return r;
	endfunction

	// Offer one word, hold it until accepted, then record its expected result.
	task automatic send_word(input logic [lpht_pkg::REQ_W-1:0] req,
			input lpht_pkg::value_t val, input bit pinned, input lookup_t pinned_res);
		lookup_t res;
		while (!quiet && $urandom_range(99) < 7) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		req_type <= req;
		value    <= val;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		res = probe_table(req, val);
		if (pinned)
			res = pinned_res;
		if (res.sts == lpht_pkg::STS_FULL)
			full_inserts++;
		if (res.sts == lpht_pkg::STS_NOT_FOUND)
			misses++;
		pending_results.push_back(res);
		words_in++;
	endtask

	// Random word: mostly colliding pool values and values already stored.
	task automatic pick_word(output logic [lpht_pkg::REQ_W-1:0] req,
			output lpht_pkg::value_t val);
		int unsigned r;
		int unsigned k;
		r = $urandom_range(99);
		if (r < 38)
			req = lpht_pkg::REQ_INSERT;
		else if (r < 65)
			req = lpht_pkg::REQ_SEARCH;
		else if (r < 95)
			req = lpht_pkg::REQ_DELETE;
		else
			req = REQ_UNUSED;
		r = $urandom_range(99);
		if (r < 45) begin
			val = pool[$urandom_range(POOL_N - 1)];
		end else if (r < 70) begin
			k = $urandom_range(SLOTS - 1);
			for (int n = 0; n < SLOTS; n++)
				if (!tbl_used[k])
					k = (k + 1) % SLOTS;
			val = tbl_used[k] ? tbl_val[k] : lpht_pkg::value_t'($urandom);
		end else if (r < 88) begin
			val = lpht_pkg::value_t'($urandom);
		end else begin
			case ($urandom_range(2))
				0: val = '0;
				1: val = VALUE_MAX;
				default: val = lpht_pkg::value_t'((lpht_pkg::value_t'($urandom) / SLOTS)
					* SLOTS);
			endcase
		end
	endtask

	// New pool of values clustered on a few home slots, the wrap slot among them.
	task automatic refill_pool();
		int unsigned res;
		for (int i = 0; i < POOL_N; i++) begin
			case ($urandom_range(3))
				0: res = 0;
				1: res = 1;
				2: res = 2;
				default: res = SLOTS - 1;
			endcase
			pool[i] = lpht_pkg::value_t'((lpht_pkg::value_t'($urandom) / SLOTS) * SLOTS
				+ res);
		end
	endtask

	// Stop offering words until every expected result has come back.
	task automatic drain_results();
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	// Receiver: check each accepted result word and drive out_stall.
	initial begin
		int unsigned hold_left;
		lookup_t     want;
		hold_left = 0;
		out_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && out_valid && !out_stall) begin
				words_out++;
				if (pending_results.size() == 0) begin
					report_mismatch($sformatf("unexpected result word status %0d position %0d",
						status, position));
				end else begin
					want = pending_results.pop_front();
					if (status !== want.sts)
						report_mismatch($sformatf("result %0d: status %0d, expected %0d",
							words_out, status, want.sts));
					if (position !== want.pos)
						report_mismatch($sformatf("result %0d: position %0d, expected %0d",
							words_out, position, want.pos));
				end
			end
			if (hold_request) begin
				hold_left    = HOLD_CYCLES;
				hold_request = 1'b0;
			end
			if (hold_left > 0) begin
				out_stall <= 1'b1;
				hold_left--;
			end else begin
				out_stall <= (!quiet && $urandom_range(99) < 7);
			end
		end
	end

	// Main sequence: reset, directed table, random phases, final check.
	initial begin
		logic [lpht_pkg::REQ_W-1:0] req;
		lpht_pkg::value_t           val;
		fail_count   = 0;
		words_in     = 0;
		words_out    = 0;
		full_inserts = 0;
		misses       = 0;
		quiet        = 1'b0;
		hold_request = 1'b0;
		for (int i = 0; i < SLOTS; i++) begin
			tbl_val[i]  = '0;
			tbl_used[i] = 1'b0;
		end
		arst_n   <= 1'b0;
		in_valid <= 1'b0;
		req_type <= lpht_pkg::REQ_INSERT;
		value    <= '0;

		// Empty table, wrap of the home slot, duplicates, unused code, full table.
		dir_rows = '{
			fixed_row(lpht_pkg::REQ_SEARCH, 31'd0, lpht_pkg::STS_NOT_FOUND, 5'd0),
			fixed_row(REQ_UNUSED, VALUE_MAX, lpht_pkg::STS_NOT_FOUND, 5'd0),
			fixed_row(lpht_pkg::REQ_INSERT, 31'd0, lpht_pkg::STS_OK, 5'd16),
			open_row(lpht_pkg::REQ_INSERT, 31'd16),
			fixed_row(lpht_pkg::REQ_INSERT, VALUE_MAX, lpht_pkg::STS_OK, 5'd15),
			open_row(lpht_pkg::REQ_INSERT, 31'd0),
			fixed_row(lpht_pkg::REQ_SEARCH, 31'd0, lpht_pkg::STS_OK, 5'd16),
			fixed_row(lpht_pkg::REQ_DELETE, 31'd0, lpht_pkg::STS_OK, 5'd16),
			open_row(lpht_pkg::REQ_SEARCH, 31'd0),
			fixed_row(lpht_pkg::REQ_DELETE, 31'd12345, lpht_pkg::STS_NOT_FOUND, 5'd0),
			open_row(lpht_pkg::REQ_INSERT, 31'd2),
			open_row(lpht_pkg::REQ_INSERT, 31'd3),
			open_row(lpht_pkg::REQ_INSERT, 31'd4),
			open_row(lpht_pkg::REQ_INSERT, 31'd5),
			open_row(lpht_pkg::REQ_INSERT, 31'd6),
			open_row(lpht_pkg::REQ_INSERT, 31'd7),
			open_row(lpht_pkg::REQ_INSERT, 31'd8),
			open_row(lpht_pkg::REQ_INSERT, 31'd9),
			open_row(lpht_pkg::REQ_INSERT, 31'd10),
			open_row(lpht_pkg::REQ_INSERT, 31'd11),
			open_row(lpht_pkg::REQ_INSERT, 31'd12),
			open_row(lpht_pkg::REQ_INSERT, 31'h2AAA_AAAA),
			open_row(lpht_pkg::REQ_INSERT, 31'h5555_5555),
			fixed_row(lpht_pkg::REQ_INSERT, 31'd77, lpht_pkg::STS_FULL, 5'd0),
			open_row(lpht_pkg::REQ_SEARCH, VALUE_MAX)
		};

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		foreach (dir_rows[i])
			send_word(dir_rows[i].req, dir_rows[i].val, dir_rows[i].pinned, dir_rows[i].res);
		drain_results();

		// Random words with idling; the receiver holds off once to fill the block.
		refill_pool();
		for (int i = 0; i < 400; i++) begin
			if (i == 100)
				hold_request = 1'b1;
			pick_word(req, val);
			send_word(req, val, 1'b0, '0);
		end
		drain_results();

		// A stretch without any idling on either side.
		refill_pool();
		quiet = 1'b1;
		for (int i = 0; i < 300; i++) begin
			pick_word(req, val);
			send_word(req, val, 1'b0, '0);
		end
		drain_results();
		quiet = 1'b0;

		// More random words, with a pause until every result is back.
		refill_pool();
		for (int i = 0; i < 425; i++) begin
			if (i == 200)
				drain_results();
			pick_word(req, val);
			send_word(req, val, 1'b0, '0);
		end
		drain_results();
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("Sent %0d request words, checked %0d result words.", words_in, words_out);
		$display("Inserts into a full table: %0d, lookups that missed: %0d, mismatches: %0d.",
			full_inserts, misses, fail_count);
		if (fail_count == 0 && pending_results.size() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

// File: sim.f
rtl/core/lpht_pkg.sv
rtl/core/lpht_home.sv
rtl/core/linear_probe_hash_table.sv
rtl/core/lpht_checker.sv
tb/sv/testbench.sv
